// ===== hdl/rdsg_pkg.sv =====
package rdsg_pkg;

   // Buffer geometry
   localparam int TEXT_LEN    = 64;   // radio text length, kept even
   localparam int NAME_LEN    = 8;
   localparam int NAME_AW     = $clog2(NAME_LEN);
   localparam int TEXT_WORDS  = (TEXT_LEN + 3) / 4;
   localparam int TEXT_AW     = $clog2(TEXT_WORDS);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_PRINT_LO = 8'd32;
   localparam logic [7:0] CHAR_PRINT_HI = 8'd127;
   localparam logic [3:0] MATCH_MAX     = 4'd15;
   localparam logic [2:0] EMERGENCY_PTY = 3'd7;

   // Configuration register indexes
   localparam logic CSR_NAME_REPEATS = 1'b0;
   localparam logic CSR_ERROR_LIMIT  = 1'b1;

   // Request kinds
   localparam logic [2:0] KIND_GROUP     = 3'd0;
   localparam logic [2:0] KIND_READ_NAME = 3'd1;
   localparam logic [2:0] KIND_READ_TEXT = 3'd2;
   localparam logic [2:0] KIND_STATUS    = 3'd3;
   localparam logic [2:0] KIND_CLEAR     = 3'd4;

   // RDS group types
   localparam logic [3:0] GROUP_BASIC = 4'd0;
   localparam logic [3:0] GROUP_PIN   = 4'd1;
   localparam logic [3:0] GROUP_TEXT  = 4'd2;
   localparam logic [3:0] GROUP_CLOCK = 4'd4;

   // Result events
   localparam logic [2:0] EV_IGNORED    = 3'd0;
   localparam logic [2:0] EV_NAME_CHARS = 3'd1;
   localparam logic [2:0] EV_NAME_CYCLE = 3'd2;
   localparam logic [2:0] EV_TEXT_CHARS = 3'd3;
   localparam logic [2:0] EV_TEXT_CYCLE = 3'd4;
   localparam logic [2:0] EV_FIELDS     = 3'd5;
   localparam logic [2:0] EV_READ       = 3'd6;

   typedef enum logic [3:0] {
      OP_IGNORE,
      OP_GROUP0,
      OP_GROUP1,
      OP_GROUP2,
      OP_GROUP4A,
      OP_GROUP_OTHER,
      OP_READ_NAME,
      OP_READ_TEXT,
      OP_STATUS,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] block_b;
      logic [15:0] block_c;
      logic [15:0] block_d;
      logic [1:0]  err_a;
      logic [1:0]  err_b;
      logic        data_ready;
      logic        data_synced;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic        stereo_flag;
      logic        compressed_flag;
      logic        static_pty_flag;
      logic        traffic_announcement;
      logic        emergency_flag;
      logic        clear_screen;
      logic        name_confirmed;
      logic [4:0]  clock_hours;
      logic [5:0]  clock_minutes;
      logic [15:0] pin_packed;
      logic [7:0]  read_char;
   } rsp_type;

   typedef struct packed {
      logic [3:0] name_repeats;
      logic [2:0] name_error_limit;
   } cfg_type;

   // Classified request as it travels from front to back
   typedef struct packed {
      op_type      op;
      logic [15:0] block_b;
      logic [15:0] block_c;
      logic [15:0] block_d;
      logic        clean;
      logic        text_ok;
      logic        name_chars;
      logic [5:0]  read_index;
   } cmd_type;

   function automatic logic is_printable(input logic [7:0] c);
      return (c > CHAR_PRINT_LO) && (c < CHAR_PRINT_HI);
   endfunction

endpackage

// ===== hdl/rdsg_ram.sv =====
module rdsg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rdsg_front.sv =====
module rdsg_front (
   input  rdsg_pkg::req_type req_data,
   input  rdsg_pkg::cfg_type cfg,
   output rdsg_pkg::cmd_type cmd
);

   logic [3:0] group_kind;
   logic       ver_a;
   logic [2:0] errs;

   assign group_kind = req_data.block_b[15:12];
   assign ver_a      = req_data.block_b[11];
   assign errs       = {1'b0, req_data.err_a} + {1'b0, req_data.err_b};

   // Classify the request and work out its acceptance conditions
   always_comb begin
      cmd.block_b    = req_data.block_b;
      cmd.block_c    = req_data.block_c;
      cmd.block_d    = req_data.block_d;
      cmd.read_index = req_data.read_index;
      cmd.clean      = (errs == 3'd0) && req_data.data_synced;
      cmd.text_ok    = (errs == 3'd0) && req_data.data_synced && req_data.data_ready;
      cmd.name_chars = (errs <= cfg.name_error_limit)
                       && rdsg_pkg::is_printable(req_data.block_d[15:8])
                       && rdsg_pkg::is_printable(req_data.block_d[7:0]);
      unique case (req_data.kind)
         rdsg_pkg::KIND_GROUP: begin
            if (group_kind == rdsg_pkg::GROUP_BASIC) begin
               cmd.op = rdsg_pkg::OP_GROUP0;
            end else if (group_kind == rdsg_pkg::GROUP_PIN) begin
               cmd.op = rdsg_pkg::OP_GROUP1;
            end else if (group_kind == rdsg_pkg::GROUP_TEXT) begin
               cmd.op = rdsg_pkg::OP_GROUP2;
            end else if (group_kind == rdsg_pkg::GROUP_CLOCK && ver_a) begin
               cmd.op = rdsg_pkg::OP_GROUP4A;
            end else begin
               cmd.op = rdsg_pkg::OP_GROUP_OTHER;
            end
         end
         rdsg_pkg::KIND_READ_NAME: cmd.op = rdsg_pkg::OP_READ_NAME;
         rdsg_pkg::KIND_READ_TEXT: cmd.op = rdsg_pkg::OP_READ_TEXT;
         rdsg_pkg::KIND_STATUS:    cmd.op = rdsg_pkg::OP_STATUS;
         rdsg_pkg::KIND_CLEAR:     cmd.op = rdsg_pkg::OP_CLEAR;
         default:                  cmd.op = rdsg_pkg::OP_IGNORE;
      endcase
   end

endmodule

// ===== hdl/rdsg_queue.sv =====
module rdsg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rdsg_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output rdsg_pkg::cmd_type head_data
);

   localparam int PW = (rdsg_pkg::QUEUE_DEPTH > 1) ? $clog2(rdsg_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(rdsg_pkg::QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(rdsg_pkg::QUEUE_DEPTH - 1);

   rdsg_pkg::cmd_type entry_ff [rdsg_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CW'(rdsg_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries until written
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/rdsg_back.sv =====
module rdsg_back (
   input  logic              clock,
   input  logic              reset,
   input  rdsg_pkg::cfg_type cfg,
   input  logic              head_valid,
   input  rdsg_pkg::cmd_type head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rdsg_pkg::rsp_type rsp_data
);

   localparam int NL = rdsg_pkg::NAME_LEN;
   localparam int TW = rdsg_pkg::TEXT_WORDS;
   localparam int AW = rdsg_pkg::TEXT_AW;
   localparam int NAME_AW_W = rdsg_pkg::NAME_AW;

   // Name and tracker state
   logic [NL-1:0][7:0] name_rx_ff, name_rx_in;
   logic [NL-1:0][7:0] name_kept_ff, name_kept_in;
   logic [1:0]         name_last_seg_ff, name_last_seg_in;
   logic [3:0]         name_match_ff, name_match_in;
   logic               name_ok_ff, name_ok_in;
   logic [5:0]         text_last_off_ff, text_last_off_in;
   logic [TW-1:0]      hi_valid_ff, hi_valid_in;
   logic [TW-1:0]      lo_valid_ff, lo_valid_in;

   // Flags, time and PIN
   logic        stereo_ff, stereo_in;
   logic        compressed_ff, compressed_in;
   logic        static_pty_ff, static_pty_in;
   logic        ta_ff, ta_in;
   logic        emergency_ff, emergency_in;
   logic        clear_latch_ff, clear_latch_in;
   logic [4:0]  hours_ff, hours_in;
   logic [5:0]  minutes_ff, minutes_in;
   logic [15:0] pin_ff, pin_in;

   // Output stage
   logic              out_valid_ff, out_valid_in;
   rdsg_pkg::rsp_type out_ff, out_in;
   logic              text_rd_ff, text_rd_in;
   logic              rd_half_ff, rd_half_in;
   logic              rd_byte_ff, rd_byte_in;
   logic              rd_hit_ff, rd_hit_in;

   // Text memory ports
   logic          hi_wr_en, lo_wr_en;
   logic [AW-1:0] hi_wr_addr, lo_wr_addr;
   logic [15:0]   hi_wr_data, lo_wr_data;
   logic          text_rd_en;
   logic [AW-1:0] text_rd_addr;
   logic [15:0]   hi_rd_data, lo_rd_data;

   logic       fire;
   logic [1:0] seg;
   logic [3:0] tseg;
   logic       ver_a;
   logic [3:0] word;
   logic       half;
   logic [5:0] off;
   logic [5:0] hi_pos, lo_pos;
   logic       name_equal;
   logic [3:0] match_inc;
   logic [2:0] ev;
   logic       cs;
   logic [7:0] name_char;
   logic [NAME_AW_W-1:0] name_idx;

   assign fire  = head_valid && (!out_valid_ff || !rsp_stall);
   assign pop   = fire;
   assign seg   = head_data.block_b[1:0];
   assign tseg  = head_data.block_b[3:0];
   assign ver_a = head_data.block_b[11];

   // Text placement: hi RAM holds positions 4w and 4w+1, lo RAM 4w+2 and 4w+3
   assign word   = ver_a ? tseg : {1'b0, tseg[3:1]};
   assign half   = ver_a ? 1'b0 : tseg[0];
   assign off    = ver_a ? {tseg, 2'b00} : {1'b0, tseg, 1'b0};
   assign hi_pos = {word, 2'b00};
   assign lo_pos = {word, 2'b10};

   assign hi_wr_addr = word[AW-1:0];
   assign lo_wr_addr = word[AW-1:0];
   assign hi_wr_data = ver_a ? head_data.block_c : head_data.block_d;
   assign lo_wr_data = head_data.block_d;

   assign text_rd_addr = head_data.read_index[AW+1:2];
   assign text_rd_en   = fire && (head_data.op == rdsg_pkg::OP_READ_TEXT);

   assign name_idx  = head_data.read_index[NAME_AW_W-1:0];
   assign name_char = (head_data.read_index < 6'(NL)) ? name_kept_ff[name_idx] : 8'd0;

   // Carry out one command against the stored state
   always_comb begin
      name_rx_in       = name_rx_ff;
      name_kept_in     = name_kept_ff;
      name_last_seg_in = name_last_seg_ff;
      name_match_in    = name_match_ff;
      name_ok_in       = name_ok_ff;
      text_last_off_in = text_last_off_ff;
      hi_valid_in      = hi_valid_ff;
      lo_valid_in      = lo_valid_ff;
      stereo_in        = stereo_ff;
      compressed_in    = compressed_ff;
      static_pty_in    = static_pty_ff;
      ta_in            = ta_ff;
      emergency_in     = emergency_ff;
      clear_latch_in   = clear_latch_ff;
      hours_in         = hours_ff;
      minutes_in       = minutes_ff;
      pin_in           = pin_ff;
      hi_wr_en         = 1'b0;
      lo_wr_en         = 1'b0;
      ev               = rdsg_pkg::EV_IGNORED;
      name_equal       = 1'b0;
      match_inc        = name_match_ff;

      // every group updates the announcement and the clear-screen latch
      if (head_data.op == rdsg_pkg::OP_GROUP0 || head_data.op == rdsg_pkg::OP_GROUP1
          || head_data.op == rdsg_pkg::OP_GROUP2 || head_data.op == rdsg_pkg::OP_GROUP4A
          || head_data.op == rdsg_pkg::OP_GROUP_OTHER) begin
         clear_latch_in = clear_latch_ff | head_data.block_b[4];
         ta_in          = head_data.block_b[5];
      end

      unique case (head_data.op)
         rdsg_pkg::OP_GROUP0: begin
            if (head_data.clean) begin
               unique case (seg)
                  2'd3:    stereo_in     = head_data.block_b[2];
                  2'd1:    compressed_in = head_data.block_b[2];
                  2'd0:    static_pty_in = head_data.block_b[2];
                  default: ;
               endcase
               ev = rdsg_pkg::EV_FIELDS;
            end
            if (head_data.name_chars) begin
               name_rx_in[{seg, 1'b0}] = head_data.block_d[15:8];
               name_rx_in[{seg, 1'b1}] = head_data.block_d[7:0];
               ev = rdsg_pkg::EV_NAME_CHARS;
               name_equal = (name_rx_in == name_kept_ff);
               match_inc  = (name_match_ff == rdsg_pkg::MATCH_MAX)
                            ? name_match_ff : name_match_ff + 4'd1;
               // wrap to a lower segment closes a name cycle
               if (seg < name_last_seg_ff) begin
                  ev = rdsg_pkg::EV_NAME_CYCLE;
                  if (name_equal) begin
                     name_match_in = match_inc;
                     if (match_inc >= cfg.name_repeats) begin
                        name_ok_in = 1'b1;
                     end
                  end else begin
                     name_kept_in  = name_rx_in;
                     name_match_in = 4'd0;
                     name_ok_in    = 1'b0;
                  end
               end
               name_last_seg_in = seg;
            end
         end
         rdsg_pkg::OP_GROUP1: begin
            if (head_data.clean) begin
               pin_in = head_data.block_d;
               if (ver_a) begin
                  emergency_in = (head_data.block_c[14:12] == rdsg_pkg::EMERGENCY_PTY);
               end
               ev = rdsg_pkg::EV_FIELDS;
            end
         end
         rdsg_pkg::OP_GROUP2: begin
            if (head_data.text_ok) begin
               // characters past the buffer end are dropped
               hi_wr_en = (ver_a || !half) && (hi_pos < rdsg_pkg::TEXT_LEN);
               lo_wr_en = (ver_a || half) && (lo_pos < rdsg_pkg::TEXT_LEN);
               if (hi_wr_en) begin
                  hi_valid_in[word[AW-1:0]] = 1'b1;
               end
               if (lo_wr_en) begin
                  lo_valid_in[word[AW-1:0]] = 1'b1;
               end
               ev = (off < text_last_off_ff) ? rdsg_pkg::EV_TEXT_CYCLE
                                              : rdsg_pkg::EV_TEXT_CHARS;
               text_last_off_in = off;
            end
         end
         rdsg_pkg::OP_GROUP4A: begin
            if (head_data.clean) begin
               minutes_in = head_data.block_d[11:6];
               hours_in   = {head_data.block_c[0], head_data.block_d[15:12]};
               ev = rdsg_pkg::EV_FIELDS;
            end
         end
         rdsg_pkg::OP_READ_NAME,
         rdsg_pkg::OP_READ_TEXT,
         rdsg_pkg::OP_STATUS: begin
            ev = rdsg_pkg::EV_READ;
         end
         rdsg_pkg::OP_CLEAR: begin
            name_rx_in       = {NL{rdsg_pkg::CHAR_SPACE}};
            name_kept_in     = {NL{rdsg_pkg::CHAR_SPACE}};
            name_last_seg_in = 2'd0;
            name_match_in    = 4'd0;
            name_ok_in       = 1'b0;
            text_last_off_in = 6'd0;
            hi_valid_in      = '0;
            lo_valid_in      = '0;
         end
         rdsg_pkg::OP_GROUP_OTHER,
         rdsg_pkg::OP_IGNORE: ;
         default: ;
      endcase

      // status read reports the latch, then drops it
      cs = clear_latch_in;
      if (head_data.op == rdsg_pkg::OP_STATUS) begin
         clear_latch_in = 1'b0;
      end
   end

   // Build the result as it leaves the back end
   always_comb begin
      out_in.event_res            = ev;
      out_in.stereo_flag          = stereo_in;
      out_in.compressed_flag      = compressed_in;
      out_in.static_pty_flag      = static_pty_in;
      out_in.traffic_announcement = ta_in;
      out_in.emergency_flag       = emergency_in;
      out_in.clear_screen         = cs;
      out_in.name_confirmed       = name_ok_in;
      out_in.clock_hours          = hours_in;
      out_in.clock_minutes        = minutes_in;
      out_in.pin_packed           = pin_in;
      out_in.read_char            = (head_data.op == rdsg_pkg::OP_READ_NAME) ? name_char : 8'd0;
      text_rd_in = (head_data.op == rdsg_pkg::OP_READ_TEXT)
                   && (head_data.read_index < rdsg_pkg::TEXT_LEN);
      rd_half_in = head_data.read_index[1];
      rd_byte_in = head_data.read_index[0];
      rd_hit_in  = head_data.read_index[1] ? lo_valid_ff[text_rd_addr]
                                           : hi_valid_ff[text_rd_addr];
      out_valid_in = fire || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_rx_ff       <= {NL{rdsg_pkg::CHAR_SPACE}};
         name_kept_ff     <= {NL{rdsg_pkg::CHAR_SPACE}};
         name_last_seg_ff <= 2'd0;
         name_match_ff    <= 4'd0;
         name_ok_ff       <= 1'b0;
         text_last_off_ff <= 6'd0;
         hi_valid_ff      <= '0;
         lo_valid_ff      <= '0;
         stereo_ff        <= 1'b0;
         compressed_ff    <= 1'b0;
         static_pty_ff    <= 1'b0;
         ta_ff            <= 1'b0;
         emergency_ff     <= 1'b0;
         clear_latch_ff   <= 1'b0;
         hours_ff         <= 5'd0;
         minutes_ff       <= 6'd0;
         pin_ff           <= 16'd0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (fire) begin
            name_rx_ff       <= name_rx_in;
            name_kept_ff     <= name_kept_in;
            name_last_seg_ff <= name_last_seg_in;
            name_match_ff    <= name_match_in;
            name_ok_ff       <= name_ok_in;
            text_last_off_ff <= text_last_off_in;
            hi_valid_ff      <= hi_valid_in;
            lo_valid_ff      <= lo_valid_in;
            stereo_ff        <= stereo_in;
            compressed_ff    <= compressed_in;
            static_pty_ff    <= static_pty_in;
            ta_ff            <= ta_in;
            emergency_ff     <= emergency_in;
            clear_latch_ff   <= clear_latch_in;
            hours_ff         <= hours_in;
            minutes_ff       <= minutes_in;
            pin_ff           <= pin_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the result payload while stalled
   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff     <= out_in;
         text_rd_ff <= text_rd_in;
         rd_half_ff <= rd_half_in;
         rd_byte_ff <= rd_byte_in;
         rd_hit_ff  <= rd_hit_in;
      end
   end

   rdsg_ram #(.WIDTH(16), .DEPTH(TW)) u_text_hi (
      .clock   (clock),
      .wr_en   (fire && hi_wr_en),
      .wr_addr (hi_wr_addr),
      .wr_data (hi_wr_data),
      .rd_en   (text_rd_en),
      .rd_addr (text_rd_addr),
      .rd_data (hi_rd_data)
   );

   rdsg_ram #(.WIDTH(16), .DEPTH(TW)) u_text_lo (
      .clock   (clock),
      .wr_en   (fire && lo_wr_en),
      .wr_addr (lo_wr_addr),
      .wr_data (lo_wr_data),
      .rd_en   (text_rd_en),
      .rd_addr (text_rd_addr),
      .rd_data (lo_rd_data)
   );

   // Pick the text byte; entries never written since a clear read as spaces
   logic [15:0] rd_word;
   logic [7:0]  text_char;

   assign rd_word   = rd_half_ff ? lo_rd_data : hi_rd_data;
   assign text_char = !rd_hit_ff ? rdsg_pkg::CHAR_SPACE
                    : (rd_byte_ff ? rd_word[7:0] : rd_word[15:8]);

   always_comb begin
      rsp_data = out_ff;
      if (text_rd_ff) begin
         rsp_data.read_char = text_char;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ===== hdl/rds_group_decoder.sv =====
// Path: an accepted request waits in a two-entry queue that parts front and back,
// then the back end registers its result. Throughput: one request per cycle while
// the result side does not stall, set by the back end applying one command per
// cycle to the flag registers and the text memories (one write port each).
// Reset: synchronous, active high; buffers read as spaces, flags, trackers,
// time and PIN clear, configuration returns to four repeats and error limit two.
module rds_group_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rdsg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rdsg_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [3:0]        csr_wdata
);

   rdsg_pkg::cfg_type cfg_ff, cfg_in;
   rdsg_pkg::cmd_type front_cmd;
   rdsg_pkg::cmd_type head_data;
   logic              queue_full;
   logic              head_valid;
   logic              pop;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rdsg_pkg::CSR_NAME_REPEATS: cfg_in.name_repeats     = csr_wdata;
            rdsg_pkg::CSR_ERROR_LIMIT:  cfg_in.name_error_limit = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.name_repeats     <= 4'd4;
         cfg_ff.name_error_limit <= 3'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = queue_full;

   rdsg_front u_front (
      .req_data (req_data),
      .cfg      (cfg_ff),
      .cmd      (front_cmd)
   );

   rdsg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !queue_full),
      .push_data  (front_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   rdsg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== hdl/rdsg_checker.sv =====
module rdsg_props (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input rdsg_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rdsg_pkg::rsp_type rsp_data
);

   // No result and no back-pressure straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result valid or request stalled right after reset");

   // A stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Characters come back only on read replies
   a_char_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res != rdsg_pkg::EV_READ) |-> rsp_data.read_char == 8'd0)
      else $error("character on a non-read result");

   // Events stay within the defined codes
   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.event_res <= rdsg_pkg::EV_READ)
      else $error("undefined event code");

endmodule

bind rds_group_decoder rdsg_props u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/rdsg_checker.sv =====
`timescale 1ns / 100ps

module rdsg_checker #(
   parameter logic REG_REPEATS   = rdsg_pkg::CSR_NAME_REPEATS,
   parameter logic REG_ERR_LIMIT = rdsg_pkg::CSR_ERROR_LIMIT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rdsg_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rdsg_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [3:0]        csr_wdata,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count
);
   import rdsg_pkg::*;

   // Positions in the stored flag word
   localparam int FLAG_STEREO     = 0;
   localparam int FLAG_COMPRESSED = 1;
   localparam int FLAG_STATIC_PTY = 2;
   localparam int FLAG_TA         = 3;
   localparam int FLAG_EMERGENCY  = 4;
   localparam int FLAG_CLEAR      = 5;

   // Shadow of the decoder state
   logic [7:0]  rx_name   [NAME_LEN];
   logic [7:0]  kept_name [NAME_LEN];
   logic [7:0]  text_mem  [TEXT_LEN];
   logic [1:0]  seg_prev;
   logic [3:0]  match_run;
   logic        confirmed;
   logic [5:0]  text_off_prev;
   logic [5:0]  flags;
   logic [4:0]  hours_q;
   logic [5:0]  minutes_q;
   logic [15:0] pin_word;
   logic [3:0]  repeats_cfg;
   logic [2:0]  err_limit_cfg;

   rsp_type     expected_rsp [$];
   int          accepted_count;
   int          returned_count;

   assign pending_count = accepted_count - returned_count;
   assign checked_count = returned_count;

   // Blank all buffers and drop the trackers
   task automatic clear_store();
      for (int i = 0; i < NAME_LEN; i++) begin
         rx_name[i]   = CHAR_SPACE;
         kept_name[i] = CHAR_SPACE;
      end
      for (int i = 0; i < TEXT_LEN; i++)
         text_mem[i] = CHAR_SPACE;
      seg_prev      = 2'd0;
      match_run     = 4'd0;
      confirmed     = 1'b0;
      text_off_prev = 6'd0;
   endtask

   task automatic store_text(input int pos, input logic [7:0] ch);
      if (pos < TEXT_LEN)
         text_mem[pos] = ch;
   endtask

   function automatic logic name_char_ok(input logic [7:0] c);
      return (c >= 8'h21) && (c <= 8'h7E);
   endfunction

   // Apply one request to the shadow state and work out its response
   task automatic decode_request(input req_type r, output rsp_type y);
      logic [3:0] grp;
      logic       ver_a;
      logic       clean;
      logic       same;
      logic       latch_out;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] ch;
      logic [2:0] ev;
      int         errs;
      int         seg;
      int         off;
      int         idx;

      grp   = r.block_b[15:12];
      ver_a = r.block_b[11];
      errs  = int'(r.err_a) + int'(r.err_b);
      clean = (errs == 0) && r.data_synced;
      idx   = int'(r.read_index);
      ev    = EV_IGNORED;
      ch    = 8'h00;

      case (r.kind)
         KIND_GROUP: begin
            flags[FLAG_CLEAR] = flags[FLAG_CLEAR] | r.block_b[4];
            flags[FLAG_TA]    = r.block_b[5];
            if (grp == GROUP_BASIC) begin
               seg = int'(r.block_b[1:0]);
               if (clean) begin
                  // segment picks which identification bit block B carries
                  if (seg == 3)
                     flags[FLAG_STEREO] = r.block_b[2];
                  else if (seg == 1)
                     flags[FLAG_COMPRESSED] = r.block_b[2];
                  else if (seg == 0)
                     flags[FLAG_STATIC_PTY] = r.block_b[2];
                  ev = EV_FIELDS;
               end
               hi = r.block_d[15:8];
               lo = r.block_d[7:0];
               if (errs <= int'(err_limit_cfg) && name_char_ok(hi) && name_char_ok(lo)) begin
                  rx_name[2 * seg]     = hi;
                  rx_name[2 * seg + 1] = lo;
                  ev = EV_NAME_CHARS;
                  // wrap of the segment address closes a name cycle
                  if (seg < int'(seg_prev)) begin
                     ev   = EV_NAME_CYCLE;
                     same = 1'b1;
                     for (int i = 0; i < NAME_LEN; i++)
                        if (rx_name[i] != kept_name[i])
                           same = 1'b0;
                     if (same) begin
                        if (match_run != 4'd15)
                           match_run = match_run + 4'd1;
                        if (match_run >= repeats_cfg)
                           confirmed = 1'b1;
                     end else begin
                        for (int i = 0; i < NAME_LEN; i++)
                           kept_name[i] = rx_name[i];
                        match_run = 4'd0;
                        confirmed = 1'b0;
                     end
                  end
                  seg_prev = 2'(seg);
               end
            end else if (grp == GROUP_PIN) begin
               if (clean) begin
                  pin_word = r.block_d;
                  if (ver_a)
                     flags[FLAG_EMERGENCY] = (r.block_c[14:12] == EMERGENCY_PTY);
                  ev = EV_FIELDS;
               end
            end else if (grp == GROUP_TEXT) begin
               if (clean && r.data_ready) begin
                  seg = int'(r.block_b[3:0]);
                  if (ver_a) begin
                     off = 4 * seg;
                     store_text(off,     r.block_c[15:8]);
                     store_text(off + 1, r.block_c[7:0]);
                     store_text(off + 2, r.block_d[15:8]);
                     store_text(off + 3, r.block_d[7:0]);
                  end else begin
                     off = 2 * seg;
                     store_text(off,     r.block_d[15:8]);
                     store_text(off + 1, r.block_d[7:0]);
                  end
                  ev = (off < int'(text_off_prev)) ? EV_TEXT_CYCLE : EV_TEXT_CHARS;
                  text_off_prev = 6'(off);
               end
            end else if (grp == GROUP_CLOCK && ver_a) begin
               if (clean) begin
                  minutes_q = r.block_d[11:6];
                  hours_q   = {r.block_c[0], r.block_d[15:12]};
                  ev = EV_FIELDS;
               end
            end
         end
         KIND_READ_NAME: begin
            ev = EV_READ;
            if (idx < NAME_LEN)
               ch = kept_name[idx];
         end
         KIND_READ_TEXT: begin
            ev = EV_READ;
            if (idx < TEXT_LEN)
               ch = text_mem[idx];
         end
         KIND_STATUS: ev = EV_READ;
         KIND_CLEAR:  clear_store();
         default: ;
      endcase

      // status read reports the latch, then drops it
      latch_out = flags[FLAG_CLEAR];
      if (r.kind == KIND_STATUS)
         flags[FLAG_CLEAR] = 1'b0;

      y.event_res            = ev;
      y.stereo_flag          = flags[FLAG_STEREO];
      y.compressed_flag      = flags[FLAG_COMPRESSED];
      y.static_pty_flag      = flags[FLAG_STATIC_PTY];
      y.traffic_announcement = flags[FLAG_TA];
      y.emergency_flag       = flags[FLAG_EMERGENCY];
      y.clear_screen         = latch_out;
      y.name_confirmed       = confirmed;
      y.clock_hours          = hours_q;
      y.clock_minutes        = minutes_q;
      y.pin_packed           = pin_word;
      y.read_char            = ch;
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   // Track writes, predict each request, compare each response
   always @(posedge clock) begin : monitor
      rsp_type predicted;
      rsp_type want;

      if (reset) begin
         clear_store();
         flags          = 6'd0;
         hours_q        = 5'd0;
         minutes_q      = 6'd0;
         pin_word       = 16'd0;
         repeats_cfg    = 4'd4;
         err_limit_cfg  = 3'd2;
         fail_count     = 0;
         expected_rsp.delete();
         accepted_count <= 0;
         returned_count <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_REPEATS)
               repeats_cfg = csr_wdata;
            else if (csr_index == REG_ERR_LIMIT)
               err_limit_cfg = csr_wdata[2:0];
         end
         if (req_valid && !req_stall) begin
            decode_request(req_data, predicted);
            expected_rsp.push_back(predicted);
            accepted_count <= accepted_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            returned_count <= returned_count + 1;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: response with no request outstanding, got 0x%0h",
                        $time, rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               check_field("event_res", 16'(want.event_res), 16'(rsp_data.event_res));
               check_field("stereo_flag", 16'(want.stereo_flag), 16'(rsp_data.stereo_flag));
               check_field("compressed_flag", 16'(want.compressed_flag),
                           16'(rsp_data.compressed_flag));
               check_field("static_pty_flag", 16'(want.static_pty_flag),
                           16'(rsp_data.static_pty_flag));
               check_field("traffic_announcement", 16'(want.traffic_announcement),
                           16'(rsp_data.traffic_announcement));
               check_field("emergency_flag", 16'(want.emergency_flag),
                           16'(rsp_data.emergency_flag));
               check_field("clear_screen", 16'(want.clear_screen), 16'(rsp_data.clear_screen));
               check_field("name_confirmed", 16'(want.name_confirmed),
                           16'(rsp_data.name_confirmed));
               check_field("clock_hours", 16'(want.clock_hours), 16'(rsp_data.clock_hours));
               check_field("clock_minutes", 16'(want.clock_minutes),
                           16'(rsp_data.clock_minutes));
               check_field("pin_packed", want.pin_packed, rsp_data.pin_packed);
               check_field("read_char", 16'(want.read_char), 16'(rsp_data.read_char));
            end
         end
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import rdsg_pkg::*;

   // Configuration register indexes
   localparam logic REG_REPEATS   = CSR_NAME_REPEATS;
   localparam logic REG_ERR_LIMIT = CSR_ERROR_LIMIT;

   // Request kinds the block leaves unused
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   localparam int ITEMS_PER_SETTING = 56;
   localparam int DRAIN_GUARD       = 20000;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    req_valid  = 1'b0;
   logic    req_stall;
   req_type req_data   = '0;
   logic    rsp_valid;
   logic    rsp_stall  = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en  = 1'b0;
   logic    csr_index  = 1'b0;
   logic [3:0] csr_wdata = 4'd0;

   int fail_count;
   int pending_count;
   int checked_count;

   int send_idle_pct  = 16;
   int recv_stall_pct = 62;
   int items_sent     = 0;
   int cur_repeats    = 4;

   rds_group_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rdsg_checker #(
      .REG_REPEATS   (REG_REPEATS),
      .REG_ERR_LIMIT (REG_ERR_LIMIT)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_stall_pct);
   end

   function automatic logic [15:0] bword(input logic [3:0] grp, input logic ver_a,
                                         input logic [10:0] low);
      return {grp, ver_a, low};
   endfunction

   function automatic req_type group_req(input logic [15:0] b, c, d,
                                         input logic [1:0] ea, eb,
                                         input logic ready, synced);
      req_type r;
      r.kind        = KIND_GROUP;
      r.block_b     = b;
      r.block_c     = c;
      r.block_d     = d;
      r.err_a       = ea;
      r.err_b       = eb;
      r.data_ready  = ready;
      r.data_synced = synced;
      r.read_index  = 6'($urandom);
      return r;
   endfunction

   function automatic req_type read_req(input logic [2:0] kind, input logic [5:0] idx);
      req_type r;
      r.kind        = kind;
      r.block_b     = 16'($urandom);
      r.block_c     = 16'($urandom);
      r.block_d     = 16'($urandom);
      r.err_a       = 2'($urandom);
      r.err_b       = 2'($urandom);
      r.data_ready  = 1'($urandom);
      r.data_synced = 1'($urandom);
      r.read_index  = idx;
      return r;
   endfunction

   // Offer one request, idling first at random, and hold it until taken
   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Hold off until every outstanding response has come back
   task automatic wait_for_drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic write_csr(input logic idx, input logic [3:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int k);
      logic [3:0] rep;
      logic [2:0] lim;
      case (k)
         0:       begin rep = 4'd1;  lim = 3'd0; end
         1:       begin rep = 4'd15; lim = 3'd6; end
         2:       begin rep = 4'd4;  lim = 3'd2; end
         3:       begin rep = 4'd2;  lim = 3'd3; end
         4:       begin rep = 4'd15; lim = 3'd0; end
         5:       begin rep = 4'd1;  lim = 3'd6; end
         6:       begin rep = 4'd3;  lim = 3'd1; end
         7:       begin rep = 4'd8;  lim = 3'd5; end
         default: begin rep = 4'd1;  lim = 3'd2; end
      endcase
      write_csr(REG_REPEATS, rep);
      write_csr(REG_ERR_LIMIT, {1'b0, lim});
      csr_wr_en   <= 1'b0;
      cur_repeats = int'(rep);
   endtask

   // Repeated station name cycles, with the odd flaw
   task automatic send_name_burst();
      logic [7:0]  chars [NAME_LEN];
      logic [15:0] b;
      logic [15:0] d;
      logic [1:0]  ea;
      logic [1:0]  eb;
      int          cycles;
      for (int i = 0; i < NAME_LEN; i++)
         chars[i] = 8'($urandom_range(33, 126));
      cycles = cur_repeats + 1 + $urandom_range(0, 2);
      for (int n = 0; n < cycles; n++) begin
         for (int seg = 0; seg < 4; seg++) begin
            if ($urandom_range(0, 59) == 0)
               chars[$urandom_range(0, NAME_LEN - 1)] = 8'($urandom_range(33, 126));
            b = 16'($urandom);
            b[15:12] = GROUP_BASIC;
            b[4]     = ($urandom_range(0, 7) == 0);
            b[1:0]   = 2'(seg);
            d = {chars[2 * seg], chars[2 * seg + 1]};
            if ($urandom_range(0, 59) == 0)
               d[7:0] = $urandom_range(0, 1) ? 8'h20 : 8'h7F;
            ea = 2'd0;
            eb = 2'd0;
            if ($urandom_range(0, 7) == 0) begin
               ea = 2'($urandom);
               eb = 2'($urandom);
            end
            send_request(group_req(b, 16'($urandom), d, ea, eb, 1'($urandom),
                                   $urandom_range(0, 7) != 0));
         end
      end
   endtask

   // One pass of radio text segments, A or B version
   task automatic send_text_burst();
      logic [15:0] b;
      logic [1:0]  ea;
      logic        ver_a;
      logic        ready;
      logic        synced;
      int          start;
      ver_a = 1'($urandom);
      start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      for (int seg = start; seg < 16; seg++) begin
         b = 16'($urandom);
         b[15:12] = GROUP_TEXT;
         b[11]    = ver_a;
         b[4]     = ($urandom_range(0, 7) == 0);
         b[3:0]   = 4'(seg);
         ready  = 1'b1;
         synced = 1'b1;
         ea     = 2'd0;
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0:       ready  = 1'b0;
               1:       synced = 1'b0;
               default: ea     = 2'($urandom_range(1, 3));
            endcase
         end
         send_request(group_req(b, 16'($urandom), 16'($urandom), ea, 2'd0, ready, synced));
      end
   endtask

   // PIN and clock time groups
   task automatic send_misc_group();
      logic [15:0] b;
      logic [15:0] c;
      logic [1:0]  ea;
      logic [1:0]  eb;
      b = 16'($urandom);
      c = 16'($urandom);
      b[4] = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 2))
         0: begin
            b[15:12] = GROUP_PIN;
            if ($urandom_range(0, 1))
               c[14:12] = EMERGENCY_PTY;
         end
         1: begin
            b[15:12] = GROUP_CLOCK;
            b[11]    = 1'b1;
         end
         default: b[15:12] = GROUP_CLOCK;
      endcase
      ea = 2'd0;
      eb = 2'd0;
      if ($urandom_range(0, 5) == 0) begin
         ea = 2'($urandom);
         eb = 2'($urandom);
      end
      send_request(group_req(b, c, 16'($urandom), ea, eb, 1'($urandom),
                             $urandom_range(0, 7) != 0));
   endtask

   task automatic send_read();
      int pick;
      pick = $urandom_range(0, 11);
      if (pick < 4)
         send_request(read_req(KIND_READ_NAME, ($urandom_range(0, 3) != 0) ?
                               6'($urandom_range(0, NAME_LEN - 1)) : 6'($urandom)));
      else if (pick < 8)
         send_request(read_req(KIND_READ_TEXT, 6'($urandom)));
      else if (pick < 11)
         send_request(read_req(KIND_STATUS, 6'($urandom)));
      else
         send_request(read_req(KIND_CLEAR, 6'($urandom)));
   endtask

   // Anything at all, unused kinds and group types among it
   task automatic send_noise();
      req_type r;
      r = read_req($urandom_range(0, 1) ? KIND_GROUP : 3'($urandom_range(0, 7)), 6'($urandom));
      send_request(r);
   endtask

   task automatic send_random_burst();
      int pick;
      if ($urandom_range(0, 39) == 0)
         wait_for_drain();
      pick = $urandom_range(0, 99);
      if (pick < 35)
         send_name_burst();
      else if (pick < 55)
         send_text_burst();
      else if (pick < 65)
         send_misc_group();
      else if (pick < 80)
         send_read();
      else
         send_noise();
   endtask

   // Run time limit
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int target;
      int failures;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty buffers and read ranges
      send_request(read_req(KIND_STATUS, 6'd0));
      send_request(read_req(KIND_READ_NAME, 6'd0));
      send_request(read_req(KIND_READ_NAME, 6'd63));
      send_request(read_req(KIND_READ_TEXT, 6'd63));
      // name cycle with extreme printable characters and all flag bits
      send_request(group_req(bword(GROUP_BASIC, 1'b1, 11'h034), 16'h0000, 16'h217E,
                             2'd0, 2'd0, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_BASIC, 1'b0, 11'h025), 16'hFFFF, 16'h4243,
                             2'd0, 2'd0, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_BASIC, 1'b1, 11'h026), 16'h0000, 16'h4445,
                             2'd0, 2'd0, 1'b0, 1'b1));
      send_request(group_req(bword(GROUP_BASIC, 1'b1, 11'h027), 16'h0000, 16'h7E21,
                             2'd0, 2'd0, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_BASIC, 1'b1, 11'h034), 16'h0000, 16'h217E,
                             2'd0, 2'd0, 1'b1, 1'b1));
      // characters just outside the printable range
      send_request(group_req(bword(GROUP_BASIC, 1'b1, 11'h001), 16'h0000, 16'h2041,
                             2'd0, 2'd0, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_BASIC, 1'b1, 11'h001), 16'h0000, 16'h417F,
                             2'd0, 2'd0, 1'b1, 1'b1));
      // error sums above and at the limit
      send_request(group_req(bword(GROUP_BASIC, 1'b1, 11'h002), 16'h0000, 16'h4142,
                             2'd3, 2'd3, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_BASIC, 1'b1, 11'h001), 16'h0000, 16'h4142,
                             2'd1, 2'd1, 1'b1, 1'b0));
      // radio text: last A segment, wrap on B, not ready
      send_request(group_req(bword(GROUP_TEXT, 1'b1, 11'h00F), 16'hFFFF, 16'h0000,
                             2'd0, 2'd0, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_TEXT, 1'b0, 11'h000), 16'h0000, 16'hFFFF,
                             2'd0, 2'd0, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_TEXT, 1'b1, 11'h003), 16'h1234, 16'h5678,
                             2'd0, 2'd0, 1'b0, 1'b1));
      // PIN with emergency set, kept by version B, cleared again
      send_request(group_req(bword(GROUP_PIN, 1'b1, 11'h000), 16'h7000, 16'hFFFF,
                             2'd0, 2'd0, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_PIN, 1'b0, 11'h000), 16'h7000, 16'h0000,
                             2'd0, 2'd0, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_PIN, 1'b1, 11'h000), 16'h6FFF, 16'h1234,
                             2'd0, 2'd0, 1'b1, 1'b1));
      // clock time at its largest, then version B which is not a clock group
      send_request(group_req(bword(GROUP_CLOCK, 1'b1, 11'h000), 16'h0001, 16'hFFFF,
                             2'd0, 2'd0, 1'b1, 1'b1));
      send_request(group_req(bword(GROUP_CLOCK, 1'b0, 11'h000), 16'h0000, 16'h0000,
                             2'd0, 2'd0, 1'b1, 1'b1));
      // unknown group type
      send_request(group_req(bword(4'hF, 1'b1, 11'h7FF), 16'hFFFF, 16'hFFFF,
                             2'd0, 2'd0, 1'b1, 1'b1));
      // latch reported then dropped, unused kinds, clear and read back
      send_request(read_req(KIND_STATUS, 6'd0));
      send_request(read_req(KIND_UNUSED_LO, 6'd0));
      send_request(read_req(KIND_UNUSED_HI, 6'd63));
      send_request(read_req(KIND_READ_TEXT, 6'd60));
      send_request(read_req(KIND_CLEAR, 6'd0));
      send_request(read_req(KIND_READ_NAME, 6'd0));

      // Random: three idling mixes, three register settings each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 16; recv_stall_pct = 62; end
            1:       begin send_idle_pct = 62; recv_stall_pct = 16; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         for (int k = 0; k < 3; k++) begin
            wait_for_drain();
            repeat (4) @(posedge clock);
            apply_setting(phase * 3 + k);
            target = items_sent + ITEMS_PER_SETTING;
            while (items_sent < target)
               send_random_burst();
         end
      end

      // Drain and give the verdict
      wait_for_drain();
      repeat (8) @(posedge clock);
      failures = fail_count + pending_count;
      if (pending_count != 0)
         $display("%0t: %0d responses never arrived", $time, pending_count);
      $display("Sent %0d requests over three idling mixes and nine register settings,",
               items_sent);
      $display("checked %0d responses field by field", checked_count);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rdsg_pkg.sv
hdl/rdsg_ram.sv
hdl/rdsg_front.sv
hdl/rdsg_queue.sv
hdl/rdsg_back.sv
hdl/rds_group_decoder.sv
hdl/rdsg_checker.sv
tb/sv/rdsg_checker.sv
tb/sv/testbench.sv
